### hdl/f2pcm_pkg.sv
// Shared types and constants for the float-to-PCM sample converter.
package f2pcm_pkg;

  typedef enum logic [1:0] {
    DEPTH_8  = 2'd0,
    DEPTH_16 = 2'd1,
    DEPTH_24 = 2'd2,
    DEPTH_32 = 2'd3
  } depth_e;

  localparam logic [22:0] SCALE_8  = 23'd127;
  localparam logic [22:0] SCALE_16 = 23'd32767;
  localparam logic [22:0] SCALE_24 = 23'd8388607;
  localparam logic [31:0] OFFSET_8 = 32'd128;
  localparam logic [7:0]  EXP_BIAS_SHIFT = 8'd150;
  localparam logic [7:0]  EXP_ONE = 8'd127;
  localparam logic [7:0]  SHIFT_LIMIT = 8'd63;

endpackage

### hdl/float_to_pcm_sample_converter.sv
// Float-to-PCM converter top level: a four-stage pipeline with a register per stage.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+---------------------------------
//  sample   | sample_valid_i / sample_ready_o| sample_bits_i[31:0]
//  pcm      | pcm_valid_o / pcm_ready_i      | pcm_word_o[31:0], byte_count_o[2:0]
//  config   | cfg_we_i (no wait)             | cfg_data_i[5:0] (bit depth)
//
// One sample enters per cycle while the first stage is not held; each result passes
// through the stages multiply, float rounding, scaling shift and sign/offset in turn.
// Each full stage holds while the stage after it is stalled, so empty stages
// still fill under an output stall. Reset empties the pipeline and sets depth 16.
module float_to_pcm_sample_converter
  import f2pcm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        sample_valid_i,
  output logic        sample_ready_o,
  input  logic [31:0] sample_bits_i,
  output logic        pcm_valid_o,
  input  logic        pcm_ready_i,
  output logic [31:0] pcm_word_o,
  output logic [2:0]  byte_count_o
);

  logic [5:0] bit_depth_q;
  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, eno;

  assign eno = !vo_q || pcm_ready_i;
  assign en3 = !v3_q || eno;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign sample_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_depth_q <= 6'd16;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (cfg_we_i) bit_depth_q <= cfg_data_i;
      if (en1) v1_q <= sample_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (eno) vo_q <= v3_q;
    end
  end

  // Stage 1: decode and multiply the significand by the scale.
  depth_e      depth_d;
  logic [22:0] scale_d;
  logic [7:0]  exp_d;
  logic [23:0] mant_d;
  logic        nan_d;

  always_comb begin
    case (bit_depth_q)
      6'd8:    depth_d = DEPTH_8;
      6'd24:   depth_d = DEPTH_24;
      6'd32:   depth_d = DEPTH_32;
      default: depth_d = DEPTH_16;
    endcase
    case (depth_d)
      DEPTH_8:  scale_d = SCALE_8;
      DEPTH_24: scale_d = SCALE_24;
      default:  scale_d = SCALE_16;
    endcase
    exp_d  = sample_bits_i[30:23];
    mant_d = {1'b1, sample_bits_i[22:0]};
    nan_d  = (exp_d == 8'hFF) && (sample_bits_i[22:0] != 23'd0);
  end

  depth_e      depth1_q, depth2_q, depth3_q;
  logic [31:0] bits1_q, bits2_q, bits3_q;
  logic [46:0] prod1_q;
  logic [7:0]  exp1_q;
  logic [22:0] scale1_q, scale2_q;
  logic        neg1_q, neg2_q, neg3_q;
  logic        sat1_q, sat2_q;
  logic        zero1_q, zero2_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      depth1_q <= depth_d;
      bits1_q  <= sample_bits_i;
      prod1_q  <= mant_d * scale_d;
      exp1_q   <= exp_d;
      scale1_q <= scale_d;
      neg1_q   <= sample_bits_i[31] && !nan_d;
      sat1_q   <= nan_d || (exp_d >= EXP_ONE);
      zero1_q  <= (exp_d == 8'd0);
    end
  end

  // Stage 2: round the product to 24 significant bits where the float path applies.
  logic [3:0]  sh_d;
  logic [46:0] half_m, q_d, val_d;
  logic        up_d;
  logic [7:0]  t_d;

  always_comb begin
    case (depth1_q)
      DEPTH_8:  sh_d = prod1_q[30] ? 4'd7 : 4'd6;
      DEPTH_16: sh_d = prod1_q[38] ? 4'd15 : 4'd14;
      default:  sh_d = 4'd0;
    endcase
    half_m = 47'd0;
    q_d    = prod1_q;
    up_d   = 1'b0;
    if (sh_d != 4'd0) begin
      half_m = 47'd1 << (sh_d - 4'd1);
      q_d    = prod1_q >> sh_d;
      up_d   = ((prod1_q & half_m) != 47'd0)
               && (((prod1_q & (half_m - 47'd1)) != 47'd0) || q_d[0]);
    end
    val_d = q_d + {46'd0, up_d};
    t_d   = EXP_BIAS_SHIFT - exp1_q - {4'd0, sh_d};
  end

  logic [46:0] val2_q;
  logic [7:0]  t2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      depth2_q <= depth1_q;
      bits2_q  <= bits1_q;
      scale2_q <= scale1_q;
      neg2_q   <= neg1_q;
      sat2_q   <= sat1_q;
      zero2_q  <= zero1_q;
      val2_q   <= val_d;
      t2_q     <= t_d;
    end
  end

  // Stage 3: scale by the exponent, rounding half away from zero; saturate or zero.
  logic [47:0] shifted_d;
  logic [23:0] mag_d;

  always_comb begin
    shifted_d = 48'd0;
    if (t2_q < SHIFT_LIMIT) begin
      shifted_d = ({1'b0, val2_q} + (48'd1 << (t2_q - 8'd1))) >> t2_q;
    end
    if (sat2_q) begin
      mag_d = {1'b0, scale2_q};
    end else if (zero2_q) begin
      mag_d = 24'd0;
    end else begin
      mag_d = shifted_d[23:0];
    end
  end

  logic [23:0] mag3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      depth3_q <= depth2_q;
      bits3_q  <= bits2_q;
      neg3_q   <= neg2_q;
      mag3_q   <= mag_d;
    end
  end

  // Stage 4: apply sign, offset and mask, or pass the raw float at depth 32.
  logic [31:0] signed_d, word_d;
  logic [2:0]  bytes_d;

  always_comb begin
    signed_d = neg3_q ? (32'd0 - {8'd0, mag3_q}) : {8'd0, mag3_q};
    case (depth3_q)
      DEPTH_8: begin
        word_d  = {24'd0, 8'(signed_d + OFFSET_8)};
        bytes_d = 3'd1;
      end
      DEPTH_24: begin
        word_d  = {8'd0, signed_d[23:0]};
        bytes_d = 3'd3;
      end
      DEPTH_32: begin
        word_d  = bits3_q;
        bytes_d = 3'd4;
      end
      default: begin
        word_d  = {16'd0, signed_d[15:0]};
        bytes_d = 3'd2;
      end
    endcase
  end

  logic [31:0] word_q;
  logic [2:0]  bytes_q;

  always_ff @(posedge clk_i) begin
    if (eno) begin
      word_q  <= word_d;
      bytes_q <= bytes_d;
    end
  end

  assign pcm_valid_o  = vo_q;
  assign pcm_word_o   = word_q;
  assign byte_count_o = bytes_q;

endmodule

### hdl/f2pcm_checker.sv
// Port-level checker for the float-to-PCM converter and its bind.
module f2pcm_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pcm_valid_o,
  input logic        pcm_ready_i,
  input logic [31:0] pcm_word_o,
  input logic [2:0]  byte_count_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcm_valid_o && !pcm_ready_i |=> pcm_valid_o && $stable(pcm_word_o)
      && $stable(byte_count_o))
    else $error("result changed while stalled");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcm_valid_o |-> byte_count_o == 3'd1 || byte_count_o == 3'd2
      || byte_count_o == 3'd3 || byte_count_o == 3'd4)
    else $error("byte count out of range");

  a_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcm_valid_o && byte_count_o == 3'd1 |-> pcm_word_o[31:8] == 24'd0
      && pcm_word_o[7:0] != 8'd0)
    else $error("8-bit word malformed");

  a_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcm_valid_o && byte_count_o == 3'd2 |-> pcm_word_o[31:16] == 16'd0)
    else $error("16-bit word has upper bits set");

  a_upper24: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcm_valid_o && byte_count_o == 3'd3 |-> pcm_word_o[31:24] == 8'd0)
    else $error("24-bit word has upper bits set");

endmodule

bind float_to_pcm_sample_converter f2pcm_port_checker u_f2pcm_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pcm_valid_o  (pcm_valid_o),
  .pcm_ready_i  (pcm_ready_i),
  .pcm_word_o   (pcm_word_o),
  .byte_count_o (byte_count_o)
);
